// ----- hdl/msi_directory_cache_controller_assert.svh -----
// Assertion macros shared by the coherence controller.
// Each check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef MSI_DIRECTORY_CACHE_CONTROLLER_ASSERT_SVH
`define MSI_DIRECTORY_CACHE_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define MSIDC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("coherence controller check failed");
// The consequent must hold in the cycle after the antecedent.
`define MSIDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("coherence controller check failed");
`else
`define MSIDC_ASSERT_NOW(label, ante, cons)
`define MSIDC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/msidc_pkg.sv -----
package msidc_pkg;

	localparam int LINE_W = 8;
	localparam int LINES = 1 << LINE_W;
	localparam int ADDR_W = 64;
	localparam int NODE_W = 4;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Command codes on the request port.
	localparam logic [2:0] CMD_CPU_RD = 3'd0;
	localparam logic [2:0] CMD_CPU_WR = 3'd1;
	localparam logic [2:0] CMD_FETCH = 3'd2;
	localparam logic [2:0] CMD_INVAL = 3'd3;
	localparam logic [2:0] CMD_DATA = 3'd4;
	localparam logic [2:0] CMD_DATA_SH = 3'd5;

	// Line coherence states.
	localparam logic [2:0] ST_I = 3'd0;
	localparam logic [2:0] ST_S = 3'd1;
	localparam logic [2:0] ST_M = 3'd2;
	localparam logic [2:0] ST_IS = 3'd3;
	localparam logic [2:0] ST_IM = 3'd4;
	localparam logic [2:0] ST_SM = 3'd5;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_INVAL = 2'd1;
	localparam logic [1:0] ACT_DATA = 2'd2;

	localparam logic [1:0] MSG_RD_REQ = 2'd0;
	localparam logic [1:0] MSG_WR_REQ = 2'd1;
	localparam logic [1:0] MSG_DATA_BACK = 2'd2;

	localparam logic ROUTE_LOCAL = 1'b0;
	localparam logic ROUTE_NET = 1'b1;

	typedef enum logic [2:0] {
		K_CPU_RD,
		K_CPU_WR,
		K_FETCH,
		K_INVAL,
		K_DATA,
		K_NONE
	} kind_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [LINE_W-1:0] line;
		logic [ADDR_W-1:0] addr;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} req_t;

	typedef struct packed {
		logic [2:0] new_state;
		logic perm_avail;
		logic [1:0] line_op;
		logic msg_valid;
		logic [1:0] msg_type;
		logic msg_route;
		logic [ADDR_W-1:0] msg_addr;
		logic [NODE_W-1:0] msg_node_a;
		logic [NODE_W-1:0] msg_node_b;
		logic bad_request;
	} rsp_t;

	// A classified transaction as it waits in the queue.
	typedef struct packed {
		kind_t kind;
		logic local_home;
		logic [LINE_W-1:0] line;
		logic [ADDR_W-1:0] addr;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

// ----- hdl/msidc_front.sv -----
module msidc_front (
	input logic start,
	input msidc_pkg::req_t req,
	input msidc_pkg::q_status_t qstat,
	output logic push,
	output msidc_pkg::item_t item
);

	// Decode the command once so the back end only looks at a transaction class.
	always_comb begin
		push = start && !qstat.full;
		item.line = req.line;
		item.addr = req.addr;
		item.node_a = req.node_a;
		item.node_b = req.node_b;
		item.local_home = (req.node_a == req.node_b);
		unique case (req.cmd)
			msidc_pkg::CMD_CPU_RD: item.kind = msidc_pkg::K_CPU_RD;
			msidc_pkg::CMD_CPU_WR: item.kind = msidc_pkg::K_CPU_WR;
			msidc_pkg::CMD_FETCH: item.kind = msidc_pkg::K_FETCH;
			msidc_pkg::CMD_INVAL: item.kind = msidc_pkg::K_INVAL;
			msidc_pkg::CMD_DATA, msidc_pkg::CMD_DATA_SH: item.kind = msidc_pkg::K_DATA;
			default: item.kind = msidc_pkg::K_NONE;
		endcase
	end

endmodule

// ----- hdl/msidc_queue.sv -----
module msidc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input msidc_pkg::item_t push_item,
	input logic pop,
	output msidc_pkg::item_t head,
	output msidc_pkg::q_status_t status
);

	msidc_pkg::item_t slot_q [msidc_pkg::QDEPTH];
	logic [msidc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [msidc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [msidc_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	always_comb begin
		status.empty = (count_q == '0);
		status.full = (count_q == msidc_pkg::QCNT_W'(msidc_pkg::QDEPTH));
		do_push = push && !status.full;
		do_pop = pop && !status.empty;
		head = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/msidc_back.sv -----
module msidc_back (
	input logic clk,
	input logic arst_n,
	input msidc_pkg::q_status_t qstat,
	input msidc_pkg::item_t head,
	output logic pop,
	output logic done,
	output msidc_pkg::rsp_t rsp
);

	logic [2:0] line_mem_q [msidc_pkg::LINES];
	logic [msidc_pkg::LINES-1:0] line_vld_q;

	logic vld_s1;
	msidc_pkg::item_t item_s1;
	logic [2:0] rd_s1;
	logic rdv_s1;
	logic fwd_s1;
	logic [2:0] fwd_val_s1;

	logic [2:0] cur_c;
	logic [2:0] next_c;
	msidc_pkg::rsp_t rsp_c;
	logic done_q;
	msidc_pkg::rsp_t rsp_q;

	assign pop = !qstat.empty;
	assign done = done_q;
	assign rsp = rsp_q;

	always_comb begin
		// A line written at the edge that read it again takes the new value.
		if (fwd_s1) begin
			cur_c = fwd_val_s1;
		end else if (rdv_s1) begin
			cur_c = rd_s1;
		end else begin
			cur_c = msidc_pkg::ST_I;
		end
		next_c = cur_c;
		rsp_c = '0;
		unique case (item_s1.kind)
			msidc_pkg::K_CPU_RD, msidc_pkg::K_CPU_WR: begin
				unique case (cur_c)
					msidc_pkg::ST_I: begin
						rsp_c.msg_valid = 1'b1;
						if (item_s1.kind == msidc_pkg::K_CPU_RD) begin
							next_c = msidc_pkg::ST_IS;
							rsp_c.msg_type = msidc_pkg::MSG_RD_REQ;
						end else begin
							next_c = msidc_pkg::ST_IM;
							rsp_c.msg_type = msidc_pkg::MSG_WR_REQ;
						end
					end
					msidc_pkg::ST_S: begin
						if (item_s1.kind == msidc_pkg::K_CPU_RD) begin
							rsp_c.perm_avail = 1'b1;
						end else begin
							next_c = msidc_pkg::ST_SM;
							rsp_c.msg_valid = 1'b1;
							rsp_c.msg_type = msidc_pkg::MSG_WR_REQ;
						end
					end
					msidc_pkg::ST_M: rsp_c.perm_avail = 1'b1;
					default: rsp_c.bad_request = 1'b1;
				endcase
				if (rsp_c.msg_valid) begin
					rsp_c.msg_route = item_s1.local_home ? msidc_pkg::ROUTE_LOCAL
						: msidc_pkg::ROUTE_NET;
				end
			end
			msidc_pkg::K_FETCH: begin
				if (cur_c == msidc_pkg::ST_S || cur_c == msidc_pkg::ST_M) begin
					next_c = msidc_pkg::ST_S;
					rsp_c.msg_valid = 1'b1;
					rsp_c.msg_type = msidc_pkg::MSG_DATA_BACK;
					rsp_c.msg_route = msidc_pkg::ROUTE_NET;
				end
			end
			msidc_pkg::K_INVAL: begin
				if (cur_c == msidc_pkg::ST_S || cur_c == msidc_pkg::ST_M) begin
					next_c = msidc_pkg::ST_I;
					rsp_c.line_op = msidc_pkg::ACT_INVAL;
				end
			end
			msidc_pkg::K_DATA: begin
				if (cur_c == msidc_pkg::ST_IS) begin
					next_c = msidc_pkg::ST_S;
					rsp_c.line_op = msidc_pkg::ACT_DATA;
				end else if (cur_c == msidc_pkg::ST_IM || cur_c == msidc_pkg::ST_SM) begin
					next_c = msidc_pkg::ST_M;
					rsp_c.line_op = msidc_pkg::ACT_DATA;
				end
			end
			default: begin
			end
		endcase
		if (rsp_c.msg_valid) begin
			rsp_c.msg_addr = item_s1.addr;
			rsp_c.msg_node_a = item_s1.node_a;
			rsp_c.msg_node_b = item_s1.node_b;
		end
		rsp_c.new_state = next_c;
	end

	// State memory: one read at the queue head, one write from the execute stage.
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
			rd_s1 <= line_mem_q[head.line];
			rdv_s1 <= line_vld_q[head.line];
		end
		if (vld_s1) begin
			line_mem_q[item_s1.line] <= next_c;
		end
		fwd_val_s1 <= next_c;
		rsp_q <= rsp_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			done_q <= 1'b0;
			line_vld_q <= '0;
		end else begin
			vld_s1 <= pop;
			fwd_s1 <= pop && vld_s1 && (head.line == item_s1.line);
			done_q <= vld_s1;
			if (vld_s1) begin
				line_vld_q[item_s1.line] <= 1'b1;
			end
		end
	end

endmodule

// ----- hdl/msi_directory_cache_controller.sv -----
// An accepted transaction is written into the queue, then popped into the execute register;
// its result is registered and shown on the result strobe, where the receiver takes it.
// Throughput: one transaction per cycle; the state memory read and write forward between
// neighbouring transactions on the same line, so the execute stage never waits.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset (arst_n low, asynchronous) marks every line invalid through valid bits, empties the queue.
`include "msi_directory_cache_controller_assert.svh"

module msi_directory_cache_controller (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input msidc_pkg::req_t req,
	output logic done,
	output msidc_pkg::rsp_t rsp
);

	// The front end decodes each incoming transaction into a class and checks whether the
	// requesting node is its own home, so the message route is known before execution.
	// A two-entry queue parts the front from the back. The back end pops one transaction
	// per cycle, reads the line state memory, and in the following cycle works out the
	// next state, writes it back and registers the result for the output strobe.

	msidc_pkg::q_status_t qstat;
	msidc_pkg::item_t front_item;
	msidc_pkg::item_t head_item;
	logic push;
	logic pop;

	// The block only refuses a transaction when the queue is full.
	assign busy = qstat.full;

	msidc_front u_front (
		.start(start),
		.req(req),
		.qstat(qstat),
		.push(push),
		.item(front_item)
	);

	msidc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(front_item),
		.pop(pop),
		.head(head_item),
		.status(qstat)
	);

	msidc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.head(head_item),
		.pop(pop),
		.done(done),
		.rsp(rsp)
	);

	// Every accepted transaction produces exactly one result.
	`MSIDC_ASSERT_NOW(a_one_result, 1'b1, done == $past(start && !busy && arst_n, 3))
	// A request that hits a transient state neither grants access nor sends a message.
	`MSIDC_ASSERT_NOW(a_bad_quiet, done && rsp.bad_request, !rsp.msg_valid && !rsp.perm_avail)
	// Data arriving always leaves the line in a stable readable state.
	`MSIDC_ASSERT_NOW(a_data_stable, done && rsp.line_op == msidc_pkg::ACT_DATA, rsp.new_state == msidc_pkg::ST_S || rsp.new_state == msidc_pkg::ST_M)
	// With the back end draining every cycle, a full queue takes no push but pops, so it never stays full.
	`MSIDC_ASSERT_NEXT(a_no_stall, busy, !busy)

endmodule

// ----- tb/msi_directory_cache_controller_checker.sv -----
`timescale 1ns / 1ps

module msi_directory_cache_controller_checker
	import msidc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp,
	output int fails,
	output int pending,
	output int checked
);

	logic [2:0] line_state [LINES];
	rsp_t expected_rsp [$];
	rsp_t oldest;
	int i;

	// Works out the result of one transaction and moves the line on.
	function automatic rsp_t coherence_step(input req_t r);
		rsp_t o;
		logic [2:0] st;
		logic [2:0] nxt;
		o = '0;
		st = line_state[r.line];
		nxt = st;
		if (r.cmd == CMD_CPU_RD || r.cmd == CMD_CPU_WR) begin
			case (st)
				ST_I, ST_S: begin
					if (st == ST_S && r.cmd == CMD_CPU_RD) begin
						o.perm_avail = 1'b1;
					end else begin
						if (st == ST_S) begin
							nxt = ST_SM;
						end else begin
							nxt = (r.cmd == CMD_CPU_RD) ? ST_IS : ST_IM;
						end
						o.msg_valid = 1'b1;
						o.msg_type = (r.cmd == CMD_CPU_RD) ? MSG_RD_REQ : MSG_WR_REQ;
						o.msg_route = (r.node_a == r.node_b) ? ROUTE_LOCAL : ROUTE_NET;
						o.msg_addr = r.addr;
						o.msg_node_a = r.node_a;
						o.msg_node_b = r.node_b;
					end
				end
				ST_M: o.perm_avail = 1'b1;
				default: o.bad_request = 1'b1;
			endcase
		end else begin
			case (st)
				ST_S, ST_M: begin
					if (r.cmd == CMD_FETCH) begin
						nxt = ST_S;
						o.msg_valid = 1'b1;
						o.msg_type = MSG_DATA_BACK;
						o.msg_route = ROUTE_NET;
						o.msg_addr = r.addr;
						o.msg_node_a = r.node_a;
						o.msg_node_b = r.node_b;
					end else if (r.cmd == CMD_INVAL) begin
						nxt = ST_I;
						o.line_op = ACT_INVAL;
					end
				end
				ST_IS, ST_IM, ST_SM: begin
					if (r.cmd == CMD_DATA || r.cmd == CMD_DATA_SH) begin
						nxt = (st == ST_IS) ? ST_S : ST_M;
						o.line_op = ACT_DATA;
					end
				end
				default: ;
			endcase
		end
		line_state[r.line] = nxt;
		o.new_state = nxt;
		return o;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < LINES; i++) begin
				line_state[i] = ST_I;
			end
			expected_rsp.delete();
		end else begin
			// The older transaction leaves before a new one joins the queue.
			if (done) begin
				if (expected_rsp.size() == 0) begin
					fails++;
					$display("%0t: result with nothing expected, actual %h", $time, rsp);
				end else begin
					oldest = expected_rsp.pop_front();
					checked++;
					compare_field("new_state", oldest.new_state, rsp.new_state);
					compare_field("perm_avail", oldest.perm_avail, rsp.perm_avail);
					compare_field("line_op", oldest.line_op, rsp.line_op);
					compare_field("msg_valid", oldest.msg_valid, rsp.msg_valid);
					compare_field("msg_type", oldest.msg_type, rsp.msg_type);
					compare_field("msg_route", oldest.msg_route, rsp.msg_route);
					compare_field("msg_addr", oldest.msg_addr, rsp.msg_addr);
					compare_field("msg_node_a", oldest.msg_node_a, rsp.msg_node_a);
					compare_field("msg_node_b", oldest.msg_node_b, rsp.msg_node_b);
					compare_field("bad_request", oldest.bad_request, rsp.bad_request);
				end
			end
			if (start && !busy) begin
				expected_rsp.push_back(coherence_step(req));
			end
		end
		pending = expected_rsp.size();
	end

endmodule

// ----- tb/msi_directory_cache_controller_tb.sv -----
`timescale 1ns / 1ps

module msi_directory_cache_controller_tb;
	import msidc_pkg::*;

	// The limit is many times the length of a run when all is well.
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1500;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	int fails;
	int pending;
	int checked;
	int cycles;
	int cpu_sent;
	int msg_sent;

	msi_directory_cache_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// The checker sees every accepted transaction and every result strobe, keeps its own
	// copy of the line states and compares each result with the oldest prediction.
	msi_directory_cache_controller_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.fails(fails),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung block or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("msi_directory_cache_controller_tb NOT OK");
			$finish;
		end
	end

	// Presents one transaction from a falling edge and holds it until a rising edge
	// finds the block not busy. The task returns on the falling edge after acceptance,
	// so start stays high without a gap when the next transaction follows at once.
	task automatic issue(input logic [2:0] cmd, input logic [7:0] line,
			input logic [63:0] addr, input logic [3:0] na, input logic [3:0] nb);
		bit taken;
		taken = 1'b0;
		req.cmd = cmd;
		req.line = line;
		req.addr = addr;
		req.node_a = na;
		req.node_b = nb;
		start = 1'b1;
		if (cmd == CMD_CPU_RD || cmd == CMD_CPU_WR) begin
			cpu_sent++;
		end else begin
			msg_sent++;
		end
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	// A short gap with start low; the request lines carry noise meanwhile, which the
	// block must ignore.
	task automatic idle_gap;
		int n;
		n = $urandom_range(1, 4);
		start = 1'b0;
		repeat (n) begin
			req = $bits(req_t)'({$urandom, $urandom, $urandom});
			@(negedge clk);
		end
	endtask

	// Holds the sender back until every outstanding transaction has produced its result.
	task automatic drain;
		start = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	int k;
	int pick;
	logic [2:0] cmd;
	logic [7:0] line;
	logic [3:0] na;
	logic [3:0] nb;

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cycles = 0;
		cpu_sent = 0;
		msg_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: line 0 is walked through every state but IM (line 255 covers IM) and every
		// command, with commands that do not apply to the state mixed in, so that each is seen ignored.
		issue(CMD_FETCH, 8'd0, 64'h0, 4'd0, 4'd0);          // fetch in I
		issue(CMD_INVAL, 8'd0, 64'h0, 4'd0, 4'd0);          // invalidate in I
		issue(CMD_DATA, 8'd0, 64'h0, 4'd0, 4'd0);           // data reply in I
		issue(CMD_CPU_RD, 8'd0, 64'h0, 4'd3, 4'd3);         // I to IS, local directory
		issue(CMD_CPU_RD, 8'd0, 64'h1, 4'd3, 4'd3);         // cpu read in a transient state
		issue(CMD_CPU_WR, 8'd0, 64'h2, 4'd3, 4'd3);         // cpu write in a transient state
		issue(CMD_FETCH, 8'd0, 64'h3, 4'd1, 4'd2);          // fetch in IS is ignored
		issue(CMD_DATA, 8'd0, 64'h4, 4'd1, 4'd2);           // IS to S
		issue(CMD_DATA_SH, 8'd0, 64'h5, 4'd1, 4'd2);        // data reply in S
		issue(CMD_CPU_RD, 8'd0, 64'h6, 4'd0, 4'd15);        // read hit in S
		issue(CMD_FETCH, 8'd0, 64'hA5A5_5A5A_F0F0_0F0F, 4'd7, 4'd9);
		issue(CMD_CPU_WR, 8'd0, 64'h7, 4'd0, 4'd15);        // S to SM over the interconnect
		issue(CMD_DATA_SH, 8'd0, 64'h8, 4'd0, 4'd0);        // SM to M
		issue(CMD_DATA, 8'd0, 64'h9, 4'd0, 4'd0);           // data reply in M
		issue(CMD_CPU_WR, 8'd0, 64'hA, 4'd0, 4'd0);         // write hit in M
		issue(CMD_CPU_RD, 8'd0, 64'hB, 4'd0, 4'd0);         // read hit in M
		issue(3'd6, 8'd0, 64'hC, 4'd0, 4'd0);               // unused command codes
		issue(3'd7, 8'd0, 64'hD, 4'd0, 4'd0);
		issue(CMD_FETCH, 8'd0, 64'hE, 4'd15, 4'd0);         // M to S with data back
		issue(CMD_INVAL, 8'd0, 64'hF, 4'd0, 4'd0);          // S to I
		issue(CMD_CPU_WR, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd15);  // I to IM
		issue(CMD_DATA_SH, 8'd255, 64'h0, 4'd15, 4'd15);    // IM to M
		issue(CMD_INVAL, 8'd255, 64'h0, 4'd0, 4'd0);        // M to I
		issue(CMD_CPU_RD, 8'd128, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd0);
		drain;

		// Random part. Most transactions fall on a handful of lines, so that cpu requests,
		// directory messages and replies meet each other in every state; the rest spread
		// over the whole cache. There is no idling in the middle stretch.
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 28) cmd = CMD_CPU_RD;
			else if (pick < 52) cmd = CMD_CPU_WR;
			else if (pick < 63) cmd = CMD_FETCH;
			else if (pick < 74) cmd = CMD_INVAL;
			else if (pick < 86) cmd = CMD_DATA;
			else if (pick < 97) cmd = CMD_DATA_SH;
			else cmd = 3'($urandom_range(6, 7));
			if ($urandom_range(0, 99) < 85) begin
				line = 8'($urandom_range(0, 15));
			end else begin
				line = 8'($urandom);
			end
			na = 4'($urandom);
			nb = ($urandom_range(0, 99) < 35) ? na : 4'($urandom);
			issue(cmd, line, {$urandom, $urandom}, na, nb);
			if (k == RANDOM_ITEMS / 3) begin
				drain;
			end
			// Outside the middle stretch, a short idle gap follows about four transactions in a hundred.
			if ((k < 600 || k > 900) && $urandom_range(0, 99) < 4) begin
				idle_gap;
			end
		end
		start = 1'b0;
		drain;
		repeat (10) @(negedge clk);

		$display("Covered %0d cpu requests and %0d directory or data messages;",
			cpu_sent, msg_sent);
		$display("%0d results were checked field by field.", checked);
		if (fails == 0 && pending == 0) begin
			$display("msi_directory_cache_controller_tb OK");
		end else begin
			$display("msi_directory_cache_controller_tb NOT OK");
		end
		$finish;
	end

endmodule
